// ----- rtl/core/rsmt_pkg.sv -----
// Shared types and constants for the range sum/min/max tree.
package rsmt_pkg;

  localparam int unsigned LEAVES_DEF     = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned IN_VALUE_W     = 32;
  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned SUM_W          = 42;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_MIN   = 2'd1,
    MODE_MAX   = 2'd2,
    MODE_SUM   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_IDX  = 2'd1,
    STATUS_BAD_MODE = 2'd2
  } status_e;

endpackage

// ----- rtl/core/rsmt_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
module rsmt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/rsmt_level.sv -----
// One tree level: node storage (sum, max, min) for every node at one depth.
module rsmt_level #(
  parameter int unsigned Nodes     = 2,
  parameter int unsigned ValueBits = 32
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(Nodes>1?$clog2(Nodes):1)-1:0] waddr_i,
  input  logic [rsmt_pkg::SUM_W-1:0]          wsum_i,
  input  logic [ValueBits-1:0]                wmax_i,
  input  logic [ValueBits-1:0]                wmin_i,
  input  logic [(Nodes>1?$clog2(Nodes):1)-1:0] raddr_i,
  output logic [rsmt_pkg::SUM_W-1:0]          rsum_o,
  output logic [ValueBits-1:0]                rmax_o,
  output logic [ValueBits-1:0]                rmin_o
);

  localparam int unsigned DW = rsmt_pkg::SUM_W + 2 * ValueBits;

  logic [DW-1:0] rdata;

  rsmt_ram #(.Width(DW), .Depth(Nodes > 1 ? Nodes : 2)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i({wsum_i, wmax_i, wmin_i}),
    .raddr_i(raddr_i),
    .rdata_o(rdata)
  );

  // Split the packed row back into its fields.
  assign rsum_o = rdata[DW-1 -: rsmt_pkg::SUM_W];
  assign rmax_o = rdata[2*ValueBits-1 -: ValueBits];
  assign rmin_o = rdata[ValueBits-1:0];

endmodule

// ----- rtl/core/range_sum_min_max_tree_top.sv -----
// Range sum/min/max segment tree over LEAVES signed elements (LEAVES a power of two).
// Node storage is one RAM per tree level, root at depth 0. After reset a clearing
// pass writes zeros to one row of every level per cycle, all LEAVES rows, before
// the first item is taken. A write replaces the leaf and recombines its ancestors
// level by level, a sibling read followed by a parent write at each level. A query
// walks both range ends upward, two RAM reads per level (one per range end).
// Out-of-range writes and empty queries answer in the cycle after acceptance.
// Results wait in an output register; the next item is accepted the cycle after
// the result is taken.
module range_sum_min_max_tree_top #(
  parameter int unsigned LEAVES     = rsmt_pkg::LEAVES_DEF,
  parameter int unsigned VALUE_BITS = rsmt_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rsmt_pkg::COUNT_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rsmt_pkg::MODE_W-1:0]       mode_i,
  input  logic [rsmt_pkg::INDEX_W-1:0]      index_i,
  input  logic signed [rsmt_pkg::IN_VALUE_W-1:0] value_i,
  input  logic [rsmt_pkg::INDEX_W-1:0]      range_low_i,
  input  logic [rsmt_pkg::INDEX_W-1:0]      range_high_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rsmt_pkg::SUM_W-1:0] answer_o,
  output logic [rsmt_pkg::STATUS_W-1:0]     status_o
);

  localparam int unsigned LV  = $clog2(LEAVES);      // levels below root
  localparam int unsigned NW  = LV + 2;              // node number width
  localparam int unsigned LW  = $clog2(LV + 1) + 1;  // level counter width
  localparam int unsigned SW  = rsmt_pkg::SUM_W;
  localparam int unsigned VB  = VALUE_BITS;
  localparam logic [NW-1:0] LEAF_BASE = NW'(LEAVES);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WLEAF = 7'b0000100,
    ST_WRD   = 7'b0001000,
    ST_WUP   = 7'b0010000,
    ST_QRD   = 7'b0100000,
    ST_QACC  = 7'b1000000
  } state_e;

  state_e st_q;
  logic [rsmt_pkg::COUNT_W-1:0] count_q;
  logic [LV-1:0]  clr_q;          // row being cleared after reset
  logic [1:0]     mode_q;
  logic [NW-1:0]  l_q, r_q, node_q;
  logic [LW-1:0]  lvl_q;          // depth of current level (LV = leaves)
  logic           side_q;         // which range endpoint is being read in a query
  logic [SW-1:0]  acc_q, ssum_q;
  logic [VB-1:0]  best_q, smax_q, smin_q;
  logic [VB-1:0]  leaf_v_q;
  logic           out_valid_q;
  logic [SW-1:0]  answer_q;
  logic [1:0]     status_q;

  // Per-level port signals.
  logic           lv_we   [LV+1];
  logic [SW-1:0]  lv_sum  [LV+1];
  logic [VB-1:0]  lv_max  [LV+1];
  logic [VB-1:0]  lv_min  [LV+1];
  logic [NW-1:0]  rd_node;
  logic [NW-1:0]  wr_node;
  logic [SW-1:0]  w_sum;
  logic [VB-1:0]  w_max, w_min;
  logic [SW-1:0]  g_sum;
  logic [VB-1:0]  g_max, g_min;

  // Clear rows by counter after reset, else write the node being built.
  assign wr_node = (st_q == ST_CLEAR) ? NW'(clr_q) : node_q;

  // Chain of level cells, root at depth 0.
  for (genvar d = 0; d <= LV; d++) begin : g_lvl
    localparam int unsigned N  = 1 << d;
    localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
    rsmt_level #(.Nodes(N), .ValueBits(VB)) u_lvl (
      .clk_i  (clk_i),
      .we_i   (lv_we[d]),
      .waddr_i(AW'(wr_node)),
      .wsum_i (w_sum),
      .wmax_i (w_max),
      .wmin_i (w_min),
      .raddr_i(AW'(rd_node)),
      .rsum_o (lv_sum[d]),
      .rmax_o (lv_max[d]),
      .rmin_o (lv_min[d])
    );
    assign lv_we[d]   = (st_q == ST_CLEAR) ||
                        (st_q == ST_WLEAF && d == LV) ||
                        (st_q == ST_WUP && lvl_q == LW'(d));
  end

  // Read data of the level addressed in the previous cycle.
  logic [LW-1:0] rlvl_q;
  always_comb begin
    g_sum = '0; g_max = '0; g_min = '0;
    for (int d = 0; d <= LV; d++) begin
      if (rlvl_q == LW'(d)) begin
        g_sum = lv_sum[d]; g_max = lv_max[d]; g_min = lv_min[d];
      end
    end
  end

  // Node being read: sibling during write, endpoint during query.
  always_comb begin
    if (st_q == ST_WRD) rd_node = node_q ^ NW'(1);
    else if (!side_q)   rd_node = l_q;
    else                rd_node = r_q - NW'(1);
  end

  // Write data: zeros while clearing, leaf value, or combine of sibling with node just built.
  logic signed [VB-1:0] sib_max, sib_min, own_max, own_min;
  always_comb begin
    own_max = smax_q; own_min = smin_q;
    sib_max = g_max;  sib_min = g_min;
    if (st_q == ST_CLEAR) begin
      w_sum = '0;
      w_max = '0;
      w_min = '0;
    end else if (st_q == ST_WLEAF) begin
      w_sum = SW'(signed'(leaf_v_q));
      w_max = leaf_v_q;
      w_min = leaf_v_q;
    end else begin
      w_sum = ssum_q + g_sum;
      w_max = (sib_max > own_max) ? sib_max : own_max;
      w_min = (sib_min < own_min) ? sib_min : own_min;
    end
  end

  // Input saturation to VALUE_BITS.
  localparam logic signed [rsmt_pkg::IN_VALUE_W:0] VMAX =
      (VB >= 32) ? 33'sh0_7FFF_FFFF : 33'((64'sd1 <<< (VB-1)) - 1);
  localparam logic signed [rsmt_pkg::IN_VALUE_W:0] VMIN = -VMAX - 33'sd1;
  // Largest and smallest VALUE_BITS values, the empty answers of min and max.
  localparam logic [VB-1:0] BEST_HI = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] BEST_LO = {1'b1, {(VB-1){1'b0}}};
  logic signed [rsmt_pkg::IN_VALUE_W:0] v_ext, v_sat;
  assign v_ext = {value_i[31], value_i};
  assign v_sat = (v_ext > VMAX) ? VMAX : (v_ext < VMIN) ? VMIN : v_ext;

  logic [rsmt_pkg::COUNT_W-1:0] cnt;
  logic [rsmt_pkg::COUNT_W:0]   hi_c;
  assign cnt = (count_q > rsmt_pkg::COUNT_W'(LEAVES)) ?
               rsmt_pkg::COUNT_W'(LEAVES) : count_q;
  assign hi_c = ({1'b0, rsmt_pkg::COUNT_W'(range_high_i)} >
                 {1'b0, cnt} - 12'd1) ? {1'b0, cnt} - 12'd1 :
                {1'b0, rsmt_pkg::COUNT_W'(range_high_i)};

  assign in_ready_o  = (st_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign answer_o    = signed'(answer_q);
  assign status_o    = status_q;

  logic signed [VB-1:0] gmin_s, gmax_s, best_s;
  assign gmin_s = g_min;
  assign gmax_s = g_max;
  assign best_s = best_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      count_q     <= rsmt_pkg::COUNT_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      side_q      <= 1'b0;
      lvl_q       <= '0;
      rlvl_q      <= '0;
    end else begin
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        ST_CLEAR: begin
          clr_q <= clr_q + LV'(1);
          if (clr_q == LV'(LEAVES - 1)) st_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            mode_q   <= mode_i;
            leaf_v_q <= VB'(v_sat);
            acc_q    <= '0;
            best_q   <= (mode_i == rsmt_pkg::MODE_MIN) ? BEST_HI : BEST_LO;
            side_q   <= 1'b0;
            lvl_q    <= LW'(LV);
            if (mode_i == rsmt_pkg::MODE_WRITE) begin
              node_q <= LEAF_BASE + NW'(index_i);
              if ({1'b0, index_i} >= cnt) begin
                answer_q <= '0; status_q <= rsmt_pkg::STATUS_BAD_IDX;
                out_valid_q <= 1'b1;
              end else begin
                st_q <= ST_WLEAF;
              end
            end else if (cnt == '0 ||
                         {2'b0, range_low_i} > hi_c) begin
              answer_q <= (mode_i == rsmt_pkg::MODE_SUM) ? '0 :
                          (mode_i == rsmt_pkg::MODE_MIN) ? SW'(signed'(BEST_HI))
                                                         : SW'(signed'(BEST_LO));
              status_q <= rsmt_pkg::STATUS_OK;
              out_valid_q <= 1'b1;
            end else begin
              l_q  <= LEAF_BASE + NW'(range_low_i);
              r_q  <= LEAF_BASE + NW'(hi_c) + NW'(1);
              st_q <= ST_QRD;
            end
          end
        end
        ST_WLEAF: begin
          ssum_q <= w_sum; smax_q <= w_max; smin_q <= w_min;
          if (LV == 0) begin
            answer_q <= '0; status_q <= rsmt_pkg::STATUS_OK;
            out_valid_q <= 1'b1; st_q <= ST_IDLE;
          end else begin
            rlvl_q <= lvl_q;
            st_q   <= ST_WRD;
          end
        end
        ST_WRD: begin
          node_q <= node_q >> 1;
          lvl_q  <= lvl_q - LW'(1);
          st_q   <= ST_WUP;
        end
        ST_WUP: begin
          ssum_q <= w_sum; smax_q <= w_max; smin_q <= w_min;
          if (lvl_q == '0) begin
            answer_q <= '0; status_q <= rsmt_pkg::STATUS_OK;
            out_valid_q <= 1'b1; st_q <= ST_IDLE;
          end else begin
            rlvl_q <= lvl_q;
            st_q   <= ST_WRD;
          end
        end
        ST_QRD: begin
          if (l_q >= r_q) begin
            answer_q <= (mode_q == rsmt_pkg::MODE_SUM) ? acc_q :
                        SW'(signed'(best_q));
            status_q <= rsmt_pkg::STATUS_OK;
            out_valid_q <= 1'b1; st_q <= ST_IDLE;
          end else begin
            rlvl_q <= lvl_q;
            st_q   <= ST_QACC;
          end
        end
        ST_QACC: begin
          // Take the node read for this side if its endpoint is odd.
          if ((!side_q && l_q[0]) || (side_q && r_q[0])) begin
            if (mode_q == rsmt_pkg::MODE_MIN) begin
              if (gmin_s < best_s) best_q <= g_min;
            end else if (mode_q == rsmt_pkg::MODE_MAX) begin
              if (gmax_s > best_s) best_q <= g_max;
            end else begin
              acc_q <= acc_q + g_sum;
            end
          end
          if (!side_q) begin
            if (l_q[0]) l_q <= l_q + NW'(1);
            side_q <= 1'b1;
            st_q   <= ST_QRD;
          end else begin
            l_q    <= l_q >> 1;
            r_q    <= (r_q[0] ? r_q - NW'(1) : r_q) >> 1;
            side_q <= 1'b0;
            lvl_q  <= lvl_q - LW'(1);
            st_q   <= ST_QRD;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule
